[rtl/pbp_pkg.sv]
// pbp_pkg: shared widths, register indexes, lane scaling coefficients
// and helpers for the pixel bitfield packer; no dependencies
`default_nettype none

package pbp_pkg;

    localparam int LANES     = 4;
    localparam int PIX_W     = 32;
    localparam int CH_W      = 8;
    localparam int OBITS_W   = 6;
    localparam int BYTES_W   = 3;
    localparam int LANE_W    = 2;
    localparam int SH_W      = 5;
    // quotient of a 32-bit field by 255 needs 25 bits, remainder fits a byte
    localparam int QUO_W     = 25;
    localparam int REM_W     = 8;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_OUTPUT_BITS = 3'd0;
    localparam cfg_idx_t CFG_USE_MASKS   = 3'd1;
    localparam cfg_idx_t CFG_MASK_LANE0  = 3'd2;
    localparam cfg_idx_t CFG_MASK_LANE1  = 3'd3;
    localparam cfg_idx_t CFG_MASK_LANE2  = 3'd4;
    localparam cfg_idx_t CFG_MASK_LANE3  = 3'd5;

    localparam logic [OBITS_W-1:0] OUT_BITS_16    = 6'd16;
    localparam logic [OBITS_W-1:0] OUT_BITS_24    = 6'd24;
    localparam logic [OBITS_W-1:0] OUT_BITS_32    = 6'd32;
    localparam logic [BYTES_W-1:0] BYTES_16       = 3'd2;
    localparam logic [BYTES_W-1:0] BYTES_24       = 3'd3;
    localparam logic [BYTES_W-1:0] BYTES_32       = 3'd4;

    // floor(v / 255) == (v * RECIP_255) >> RECIP_SHIFT for any 32-bit v
    localparam logic [PIX_W-1:0] RECIP_255    = 32'h8080_8081;
    localparam int               RECIP_SHIFT  = 39;
    localparam logic [15:0]      ROUND_BIAS   = 16'd127;

    // 5-bit fields of plain 16-bit output
    localparam logic [REM_W-1:0] FIELD5_MAX   = 8'd31;
    localparam int               FIELD5_STEP  = 5;
    localparam int               FIELD5_LANES = 3;

    // mask field v = quo * 255 + rem, placed at bit position shift
    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic [REM_W-1:0] rem;
        logic [SH_W-1:0]  shift;
    } lane_coef_t;

    typedef struct packed {
        logic              en;
        logic [LANE_W-1:0] lane;
        logic [PIX_W-1:0]  mask;
    } mask_wr_t;

    // coefficients of the fixed 5-5-5 layout; also the reset masks
    function automatic lane_coef_t field5_coef(input int lane);
        lane_coef_t c;
        c = '0;
        if (lane < FIELD5_LANES) begin
            c.rem   = FIELD5_MAX;
            c.shift = SH_W'(FIELD5_STEP * lane);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/pbp_coef_unit.sv]
// pbp_coef_unit: turns a written channel mask into lane scaling coefficients
// (low bit position, field quotient and remainder by 255); uses pbp_pkg
`default_nettype none

module pbp_coef_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire pbp_pkg::mask_wr_t   wr,
    output logic                     busy,
    output pbp_pkg::lane_coef_t      coef [pbp_pkg::LANES]
);

    logic [pbp_pkg::SH_W-1:0]   tz;
    logic [pbp_pkg::PIX_W-1:0]  field;

    logic                       pend_valid_reg;
    logic [pbp_pkg::LANE_W-1:0] pend_lane_reg;
    logic [pbp_pkg::PIX_W-1:0]  pend_field_reg;
    logic [pbp_pkg::SH_W-1:0]   pend_shift_reg;

    logic [2*pbp_pkg::PIX_W-1:0] prod;
    logic [pbp_pkg::QUO_W-1:0]   quo;
    logic [pbp_pkg::PIX_W+1:0]   rem_full;

    pbp_pkg::lane_coef_t coef_reg  [pbp_pkg::LANES];
    pbp_pkg::lane_coef_t coef_next;

    // lowest set bit; a zero mask gives shift 0 and a zero field
    always_comb begin
        tz = '0;
        for (int i = pbp_pkg::PIX_W - 1; i >= 0; i--) begin
            if (wr.mask[i]) begin
                tz = pbp_pkg::SH_W'(i);
            end
        end
        field = wr.mask >> tz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= wr.en;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            pend_lane_reg  <= wr.lane;
            pend_field_reg <= field;
            pend_shift_reg <= tz;
        end
    end

    always_comb begin
        prod = {{pbp_pkg::PIX_W{1'b0}}, pend_field_reg}
             * {{pbp_pkg::PIX_W{1'b0}}, pbp_pkg::RECIP_255};
        quo  = prod[pbp_pkg::RECIP_SHIFT +: pbp_pkg::QUO_W];
        // field - 255 * quo, done as field - 256 * quo + quo
        rem_full = {2'b00, pend_field_reg}
                 - {1'b0, quo, 8'h00}
                 + {{(pbp_pkg::PIX_W + 2 - pbp_pkg::QUO_W){1'b0}}, quo};
        coef_next.quo   = quo;
        coef_next.rem   = rem_full[pbp_pkg::REM_W-1:0];
        coef_next.shift = pend_shift_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pbp_pkg::LANES; i++) begin
                coef_reg[i] <= pbp_pkg::field5_coef(i);
            end
        end else if (pend_valid_reg) begin
            coef_reg[pend_lane_reg] <= coef_next;
        end
    end

    assign busy = pend_valid_reg;
    assign coef = coef_reg;

endmodule

`default_nettype wire

[rtl/pbp_lane_scale.sv]
// pbp_lane_scale: scales one channel byte onto its mask field with
// round-half-up and moves it to the field's position; uses pbp_pkg
`default_nettype none

module pbp_lane_scale (
    input  wire logic [pbp_pkg::CH_W-1:0]  chan,
    input  wire pbp_pkg::lane_coef_t       coef,
    output logic [pbp_pkg::PIX_W-1:0]      field_out
);

    logic [pbp_pkg::PIX_W:0]   hi_part;
    logic [15:0]               lo_sum;
    logic [16:0]               lo_adj;
    logic [pbp_pkg::CH_W-1:0]  lo_quo;
    logic [pbp_pkg::PIX_W:0]   q;

    // round(c * (255*quo + rem) / 255) = c*quo + floor((c*rem + 127) / 255)
    always_comb begin
        hi_part = (pbp_pkg::PIX_W + 1)'({8'h00, coef.quo} * {25'd0, chan});
        lo_sum  = 16'({8'h00, chan} * {8'h00, coef.rem}) + pbp_pkg::ROUND_BIAS;
        // exact floor(x / 255) for x below 65535
        lo_adj  = {1'b0, lo_sum} + 17'd1 + {9'd0, lo_sum[15:8]};
        lo_quo  = lo_adj[15:8];
        q       = hi_part + {{(pbp_pkg::PIX_W + 1 - pbp_pkg::CH_W){1'b0}}, lo_quo};
        field_out = q[pbp_pkg::PIX_W-1:0] << coef.shift;
    end

endmodule

`default_nettype wire

[rtl/pixel_bitfield_packer.sv]
// pixel_bitfield_packer: top level, config registers, input and result stages
// depends on pbp_pkg, pbp_coef_unit and pbp_lane_scale
//
// usage
//   s_valid/s_ready/s_pixel_in carry one 32-bit source pixel per item, channel
//   byte n in bits 8n+7..8n. m_valid/m_ready/m_packed_pixel/m_pixel_bytes carry
//   the packed word and how many of its low bytes to emit (2, 3 or 4).
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the registers output_bits,
//   use_masks and mask_lane0..3 at indexes 0 to 5; other indexes are ignored.
//   an accepted input passes through an input register, then the lane scaling
//   (one 8x25 multiply per lane) into the result register that drives m_valid.
//   throughput is one item per cycle unless the output stalls or a mask converts.
//   a mask write is turned into lane coefficients over the next cycle by a
//   32x32 reciprocal multiply; s_ready is low during that cycle.
//   reset restores 24-bit pass-through with the 5-5-5 masks and empties both
//   stages. when the receiver stalls, the result holds and the input register
//   keeps one more item; s_ready falls once both are full.
`default_nettype none

module pixel_bitfield_packer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [pbp_pkg::PIX_W-1:0]      s_pixel_in,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [pbp_pkg::PIX_W-1:0]           m_packed_pixel,
    output logic [pbp_pkg::BYTES_W-1:0]         m_pixel_bytes,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire pbp_pkg::cfg_idx_t              cfg_index,
    input  wire logic [pbp_pkg::PIX_W-1:0]      cfg_data
);

    logic [pbp_pkg::OBITS_W-1:0] output_bits_reg;
    logic                        use_masks_reg;

    logic                        in_valid_reg;
    logic [pbp_pkg::PIX_W-1:0]   in_pixel_reg;
    logic                        out_valid_reg;
    logic [pbp_pkg::PIX_W-1:0]   out_pixel_reg;
    logic [pbp_pkg::BYTES_W-1:0] out_bytes_reg;

    logic                        cfg_fire;
    logic                        coef_busy;
    pbp_pkg::mask_wr_t           mask_wr;
    pbp_pkg::lane_coef_t         user_coef [pbp_pkg::LANES];
    pbp_pkg::lane_coef_t         lane_coef [pbp_pkg::LANES];
    logic [pbp_pkg::PIX_W-1:0]   lane_field [pbp_pkg::LANES];

    logic                        is16;
    logic                        is32;
    logic                        mask_mode;
    logic                        out_free;
    logic                        advance;
    logic [pbp_pkg::PIX_W-1:0]   packed_next;
    logic [pbp_pkg::BYTES_W-1:0] bytes_next;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_bits_reg <= pbp_pkg::OUT_BITS_24;
            use_masks_reg   <= 1'b0;
        end else if (cfg_fire) begin
            case (cfg_index)
                pbp_pkg::CFG_OUTPUT_BITS: begin
                    output_bits_reg <= cfg_data[pbp_pkg::OBITS_W-1:0];
                end
                pbp_pkg::CFG_USE_MASKS: begin
                    use_masks_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        mask_wr.en   = cfg_fire && (cfg_index inside {pbp_pkg::CFG_MASK_LANE0,
                                                      pbp_pkg::CFG_MASK_LANE1,
                                                      pbp_pkg::CFG_MASK_LANE2,
                                                      pbp_pkg::CFG_MASK_LANE3});
        mask_wr.lane = pbp_pkg::LANE_W'(cfg_index - pbp_pkg::CFG_MASK_LANE0);
        mask_wr.mask = cfg_data;
    end

    pbp_coef_unit u_coef (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (mask_wr),
        .busy    (coef_busy),
        .coef    (user_coef)
    );

    always_comb begin
        is16      = (output_bits_reg == pbp_pkg::OUT_BITS_16);
        is32      = (output_bits_reg == pbp_pkg::OUT_BITS_32);
        mask_mode = (is16 || is32) && use_masks_reg;
        for (int i = 0; i < pbp_pkg::LANES; i++) begin
            lane_coef[i] = mask_mode ? user_coef[i] : pbp_pkg::field5_coef(i);
        end
    end

    for (genvar g = 0; g < pbp_pkg::LANES; g++) begin : g_lane
        pbp_lane_scale u_scale (
            .chan      (in_pixel_reg[g*pbp_pkg::CH_W +: pbp_pkg::CH_W]),
            .coef      (lane_coef[g]),
            .field_out (lane_field[g])
        );
    end

    always_comb begin
        packed_next = '0;
        for (int i = 0; i < pbp_pkg::LANES; i++) begin
            packed_next = packed_next | lane_field[i];
        end
        if (!mask_mode && !is16) begin
            packed_next = in_pixel_reg;
        end
        bytes_next = is16 ? pbp_pkg::BYTES_16 : (is32 ? pbp_pkg::BYTES_32 : pbp_pkg::BYTES_24);
    end

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    // hold off new items while a mask is still being converted
    assign s_ready  = (!in_valid_reg || out_free) && !coef_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_pixel_reg <= s_pixel_in;
        end
        if (advance) begin
            out_pixel_reg <= packed_next;
            out_bytes_reg <= bytes_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_packed_pixel = out_pixel_reg;
    assign m_pixel_bytes  = out_bytes_reg;

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        coef_busy |-> !s_ready)
        else $error("item accepted while mask coefficients were updating");

    a_item_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("item left the input register but no result followed");

    a_bytes_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pixel_bytes == pbp_pkg::BYTES_16
                  || m_pixel_bytes == pbp_pkg::BYTES_24
                  || m_pixel_bytes == pbp_pkg::BYTES_32))
        else $error("byte count of result out of range");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken with both stages full and output stalled");

endmodule

`default_nettype wire
